FILE: src/idxl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idxl_pkg: shared types and constants for the indexed array list
// Command codes, port field widths and default sizes of the list store.
// ----------------------------------------------------------------------------
package idxl_pkg;

	// Port field widths
	localparam int unsigned CMD_W  = 3;
	localparam int unsigned POS_W  = 6;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned CNT_W  = 7;

	// Default sizes of the store
	localparam int unsigned DEPTH_DEF      = 64;
	localparam int unsigned WORD_WIDTH_DEF = 32;

	// Capacity after reset
	localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_APPEND    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_READ      = 3'd2;
	localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_OVERWRITE = 3'd4;
	localparam logic [CMD_W-1:0] CMD_COMPARE   = 3'd5;
	localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd6;

endpackage

FILE: src/indexed_array_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_array_list: dense ordered list of words with insert/remove at index
// Holds up to DEPTH words from position 0 upward in a single-port-write,
// registered-read store; inserts and removes shift entries through one
// read/write path under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd, position and value with start high; the beat
//   is taken at a rising edge where busy is low. busy then stays high until
//   the operation finishes.
//   Result channel: done pulses for exactly one cycle with read_value,
//   rejected, equal, count, empty_res and full_res. The receiver cannot stall;
//   the result must be taken in that cycle. busy is already low in the done
//   cycle, so the next command may be taken on that same edge.
//   Configuration: cfg_we writes cfg_wdata into the capacity register; write
//   it only while busy is low and no result is outstanding.
//   Sequence: append, overwrite, read, compare, clear and every rejected
//   command go from the accepting edge through the done state to the strobe.
//   Insert and remove first move each later entry once through the store's
//   read port and write port, one entry per cycle, then drain the read
//   register (insert then writes the new value) before the done state; with
//   no entry to move they go straight to the drain.
//   Reset: arst_n clears the count to zero and the capacity to 64; the store
//   contents are not cleared and need no clearing pass, since only words at
//   positions below the count ever reach a result.
// ----------------------------------------------------------------------------
module indexed_array_list
	import idxl_pkg::*;
#(
	parameter int unsigned DEPTH      = DEPTH_DEF,
	parameter int unsigned WORD_WIDTH = WORD_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// command channel
	input  logic              start,
	output logic              busy,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [POS_W-1:0]  position,
	input  logic [DATA_W-1:0] value,
	// result channel
	output logic              done,
	output logic [DATA_W-1:0] read_value,
	output logic              rejected,
	output logic              equal,
	output logic [CNT_W-1:0]  count,
	output logic              empty_res,
	output logic              full_res,
	// configuration
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_wdata
);

	localparam int unsigned AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned XA       = (AW > CNT_W) ? AW : CNT_W;
	localparam int unsigned XW       = (WORD_WIDTH > DATA_W) ? WORD_WIDTH : DATA_W;
	localparam int unsigned DEPTH_S  = (DEPTH > 127) ? 127 : DEPTH;
	localparam logic [CNT_W-1:0] DepthC = CNT_W'(DEPTH_S);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MOVE = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	// Count-width value to store address
	function automatic logic [AW-1:0] to_addr(input logic [CNT_W-1:0] x);
		logic [XA-1:0] w;
		w = XA'(x);
		return w[AW-1:0];
	endfunction

	// Port word to stored word
	function automatic logic [WORD_WIDTH-1:0] to_word(input logic [DATA_W-1:0] x);
		logic [XW-1:0] w;
		w = XW'(x);
		return w[WORD_WIDTH-1:0];
	endfunction

	// Stored word to port word
	function automatic logic [DATA_W-1:0] to_port(input logic [WORD_WIDTH-1:0] x);
		logic [XW-1:0] w;
		w = XW'(x);
		return w[DATA_W-1:0];
	endfunction

	logic [WORD_WIDTH-1:0] mem_q [DEPTH];
	logic [WORD_WIDTH-1:0] rdata_q;

	logic [1:0]        state_q;
	logic [CNT_W-1:0]  cap_q;
	logic [CNT_W-1:0]  count_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [CNT_W-1:0]  pos_q;
	logic [DATA_W-1:0] val_q;
	logic              rej_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  src_q;
	logic [CNT_W-1:0]  dst_q;
	logic              pend_q;

	logic              done_q;
	logic [DATA_W-1:0] read_value_q;
	logic              rejected_q;
	logic              equal_q;

	logic              accept;
	logic [CNT_W-1:0]  eff_cap;
	logic [CNT_W-1:0]  pos_ext;
	logic              has_room;
	logic              in_list;
	logic              rej_d;
	logic              move_end;
	logic              shift_up;

	logic                  we;
	logic [AW-1:0]         waddr;
	logic [WORD_WIDTH-1:0] wdata;
	logic                  re;
	logic [AW-1:0]         raddr;

	// Decode the command beat against the current list
	assign accept   = start && (state_q == ST_IDLE);
	assign eff_cap  = (cap_q > DepthC && DEPTH <= 127) ? DepthC : cap_q;
	assign pos_ext  = CNT_W'(position);
	assign has_room = (count_q < eff_cap) && (DEPTH > 127 || count_q < DepthC);
	assign in_list  = pos_ext < count_q;
	assign move_end = (rem_q == '0) && !pend_q;
	assign shift_up = (cmd_q == CMD_INSERT);

	always_comb begin
		unique case (cmd) inside
			CMD_APPEND:                       rej_d = !has_room;
			CMD_INSERT:                       rej_d = !(has_room && pos_ext <= count_q);
			CMD_READ, CMD_REMOVE,
			CMD_OVERWRITE, CMD_COMPARE:       rej_d = !in_list;
			CMD_CLEAR:                        rej_d = 1'b0;
			default:                          rej_d = 1'b1;
		endcase
	end

	// Steer the store's write and read ports
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		re    = 1'b0;
		raddr = '0;
		if (accept) begin
			re    = 1'b1;
			raddr = to_addr(pos_ext);
			if (!rej_d && cmd == CMD_APPEND) begin
				we    = 1'b1;
				waddr = to_addr(count_q);
				wdata = to_word(value);
			end else if (!rej_d && cmd == CMD_OVERWRITE) begin
				we    = 1'b1;
				waddr = to_addr(pos_ext);
				wdata = to_word(value);
			end
		end else if (state_q == ST_MOVE) begin
			if (pend_q) begin
				we    = 1'b1;
				waddr = to_addr(dst_q);
				wdata = rdata_q;
			end else if (move_end && shift_up) begin
				we    = 1'b1;
				waddr = to_addr(pos_q);
				wdata = to_word(val_q);
			end
			if (rem_q != '0) begin
				re    = 1'b1;
				raddr = to_addr(src_q);
			end
		end
	end

	// Store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// Sequencer: take the beat, shift entries, finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			rej_q   <= 1'b0;
			rem_q   <= '0;
			src_q   <= '0;
			dst_q   <= '0;
			pend_q  <= 1'b0;
			cmd_q   <= CMD_APPEND;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q  <= cmd;
						rej_q  <= rej_d;
						pend_q <= 1'b0;
						state_q <= ST_DONE;
						if (!rej_d) begin
							case (cmd)
								CMD_APPEND: count_q <= count_q + 1'b1;
								CMD_CLEAR:  count_q <= '0;
								CMD_INSERT: begin
									rem_q   <= count_q - pos_ext;
									src_q   <= count_q - 1'b1;
									dst_q   <= count_q;
									state_q <= ST_MOVE;
								end
								CMD_REMOVE: begin
									rem_q   <= count_q - pos_ext - 1'b1;
									src_q   <= pos_ext + 1'b1;
									dst_q   <= pos_ext;
									state_q <= ST_MOVE;
								end
								default: ;
							endcase
						end
					end
				end
				ST_MOVE: begin
					// advance the write side behind the read side
					if (pend_q) begin
						dst_q <= shift_up ? dst_q - 1'b1 : dst_q + 1'b1;
					end
					if (rem_q != '0) begin
						src_q  <= shift_up ? src_q - 1'b1 : src_q + 1'b1;
						rem_q  <= rem_q - 1'b1;
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
					end
					if (move_end) begin
						count_q <= shift_up ? count_q + 1'b1 : count_q - 1'b1;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the operands of the beat
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q <= pos_ext;
			val_q <= value;
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_DONE);
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE) begin
			rejected_q   <= rej_q;
			read_value_q <= (!rej_q && cmd_q == CMD_READ) ? to_port(rdata_q) : '0;
			equal_q      <= !rej_q && (cmd_q == CMD_COMPARE) && (rdata_q == to_word(val_q));
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign read_value = read_value_q;
	assign rejected   = rejected_q;
	assign equal      = equal_q;
	assign count      = count_q;
	assign empty_res  = (count_q == '0);
	assign full_res   = (count_q >= eff_cap);

endmodule

FILE: src/idxl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idxl_checker: port-level checks for the indexed array list
// Watches the command and result channels and the status fields.
// ----------------------------------------------------------------------------
module idxl_checker
	import idxl_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic [DATA_W-1:0] read_value,
	input logic              rejected,
	input logic              equal,
	input logic [CNT_W-1:0]  count,
	input logic              empty_res
);

	// A taken beat always occupies the block
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("command beat taken without going busy");

	// Finishing an operation always shows a result
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result strobe");

	// Empty flag tracks the count
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (empty_res == (count == '0)))
		else $error("empty flag disagrees with count");

	// A rejected beat reports no data and no match
	a_rej_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		done && rejected |-> (read_value == '0) && !equal)
		else $error("rejected result carries data");

endmodule

bind indexed_array_list idxl_checker u_idxl_checker (.*);

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the indexed array list
// Drives list commands through the start/busy channel and checks every done
// beat against a behavioral model of the list kept in this bench. Covers the
// empty list, every command, capacity limits and saturation, a capacity
// lowered below the count, and a long random run with random sender gaps.
// ----------------------------------------------------------------------------
module tb_top;
	import idxl_pkg::*;

	localparam int unsigned LIST_DEPTH = 64;
	// Code with no command behind it; the block must reject it
	localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

	typedef struct packed {
		logic [DATA_W-1:0] read_value;
		logic              rejected;
		logic              equal;
		logic [CNT_W-1:0]  count;
		logic              empty_res;
		logic              full_res;
	} list_result_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [CMD_W-1:0]  cmd;
	logic [POS_W-1:0]  position;
	logic [DATA_W-1:0] value;
	logic              done;
	logic [DATA_W-1:0] read_value;
	logic              rejected;
	logic              equal;
	logic [CNT_W-1:0]  count;
	logic              empty_res;
	logic              full_res;
	logic              cfg_we;
	logic [CNT_W-1:0]  cfg_wdata;

	// Model of the list contents, fill level and capacity register
	logic [DATA_W-1:0] list_mem [LIST_DEPTH];
	int unsigned       list_len;
	logic [CNT_W-1:0]  cap_reg;

	list_result_t      pending_results [$];
	int unsigned       fail_count;
	bit                allow_idle;

	indexed_array_list uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.position   (position),
		.value      (value),
		.done       (done),
		.read_value (read_value),
		.rejected   (rejected),
		.equal      (equal),
		.count      (count),
		.empty_res  (empty_res),
		.full_res   (full_res),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Apply one command to the list model and return the expected result
	function automatic list_result_t predict_list_op(logic [CMD_W-1:0] op,
			logic [POS_W-1:0] pos, logic [DATA_W-1:0] val);
		list_result_t res;
		int unsigned  room;
		bit           has_room;
		bit           in_list;
		room = (cap_reg > LIST_DEPTH) ? LIST_DEPTH : cap_reg;
		has_room = list_len < room;
		in_list = pos < list_len;
		res = '0;
		case (op)
			CMD_APPEND: begin
				if (has_room) begin
					list_mem[list_len] = val;
					list_len++;
				end else begin
					res.rejected = 1'b1;
				end
			end
			CMD_INSERT: begin
				if (has_room && pos <= list_len) begin
					for (int i = list_len; i > pos; i--)
						list_mem[i] = list_mem[i-1];
					list_mem[pos] = val;
					list_len++;
				end else begin
					res.rejected = 1'b1;
				end
			end
			CMD_READ: begin
				if (in_list) res.read_value = list_mem[pos];
				else res.rejected = 1'b1;
			end
			CMD_REMOVE: begin
				if (in_list) begin
					for (int i = pos; i + 1 < list_len; i++)
						list_mem[i] = list_mem[i+1];
					list_len--;
				end else begin
					res.rejected = 1'b1;
				end
			end
			CMD_OVERWRITE: begin
				if (in_list) list_mem[pos] = val;
				else res.rejected = 1'b1;
			end
			CMD_COMPARE: begin
				if (in_list) res.equal = (list_mem[pos] == val);
				else res.rejected = 1'b1;
			end
			CMD_CLEAR: begin
				list_len = 0;
			end
			default: begin
				res.rejected = 1'b1;
			end
		endcase
		res.count = list_len[CNT_W-1:0];
		res.empty_res = (list_len == 0);
		res.full_res = (list_len >= room);
		return res;
	endfunction

	// Send one command beat, after a random gap when idling is allowed
	task automatic send_cmd(logic [CMD_W-1:0] op, logic [POS_W-1:0] pos,
			logic [DATA_W-1:0] val);
		int unsigned gap;
		gap = 0;
		if (allow_idle && $urandom_range(0, 99) < 25)
			gap = $urandom_range(1, 6);
		repeat (gap) @(negedge clk);
		@(negedge clk);
		start <= 1'b1;
		cmd <= op;
		position <= pos;
		value <= val;
		// hold the beat until the block takes it
		do @(posedge clk); while (busy);
		pending_results.push_back(predict_list_op(op, pos, val));
		@(negedge clk);
		start <= 1'b0;
	endtask

	// Drain outstanding results, then write the capacity register
	task automatic write_capacity(logic [CNT_W-1:0] cap);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= cap;
		@(negedge clk);
		cfg_we <= 1'b0;
		cap_reg = cap;
	endtask

	// Check each done beat against the oldest expectation
	always @(posedge clk) begin
		list_result_t exp_res;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result beat with no command outstanding");
				fail_count++;
			end else begin
				exp_res = pending_results.pop_front();
				if (read_value !== exp_res.read_value) begin
					$error("read_value: expected %h, got %h", exp_res.read_value, read_value);
					fail_count++;
				end
				if (rejected !== exp_res.rejected) begin
					$error("rejected: expected %b, got %b", exp_res.rejected, rejected);
					fail_count++;
				end
				if (equal !== exp_res.equal) begin
					$error("equal: expected %b, got %b", exp_res.equal, equal);
					fail_count++;
				end
				if (count !== exp_res.count) begin
					$error("count: expected %0d, got %0d", exp_res.count, count);
					fail_count++;
				end
				if (empty_res !== exp_res.empty_res) begin
					$error("empty_res: expected %b, got %b", exp_res.empty_res, empty_res);
					fail_count++;
				end
				if (full_res !== exp_res.full_res) begin
					$error("full_res: expected %b, got %b", exp_res.full_res, full_res);
					fail_count++;
				end
			end
		end
	end

	// Every positional command on an empty list, plus the unused code and a clear
	task automatic test_empty_list();
		send_cmd(CMD_READ, 6'd0, 32'h0);
		send_cmd(CMD_REMOVE, 6'd0, 32'h0);
		send_cmd(CMD_COMPARE, 6'd0, 32'h0);
		send_cmd(CMD_OVERWRITE, 6'd63, 32'hFFFF_FFFF);
		send_cmd(CMD_INSERT, 6'd1, 32'h1);
		send_cmd(CMD_UNUSED, 6'd63, 32'hFFFF_FFFF);
		send_cmd(CMD_CLEAR, 6'd0, 32'h0);
	endtask

	// Each command but clear on a short list, both ends and one past the end
	task automatic test_basic_ops();
		send_cmd(CMD_APPEND, 6'd0, 32'h0000_0000);
		send_cmd(CMD_APPEND, 6'd63, 32'hFFFF_FFFF);
		send_cmd(CMD_INSERT, 6'd0, 32'hA5A5_A5A5);
		send_cmd(CMD_INSERT, 6'd3, 32'h5A5A_5A5A);
		send_cmd(CMD_INSERT, 6'd5, 32'h1);
		send_cmd(CMD_READ, 6'd3, 32'h0);
		send_cmd(CMD_READ, 6'd63, 32'h0);
		send_cmd(CMD_OVERWRITE, 6'd1, 32'h1234_5678);
		send_cmd(CMD_COMPARE, 6'd1, 32'h1234_5678);
		send_cmd(CMD_COMPARE, 6'd1, 32'h1234_5679);
		send_cmd(CMD_REMOVE, 6'd0, 32'h0);
		send_cmd(CMD_REMOVE, 6'd2, 32'h0);
	endtask

	// Capacity of one and zero, and a capacity dropped below the count
	task automatic test_capacity_edges();
		write_capacity(7'd1);
		send_cmd(CMD_APPEND, 6'd0, 32'hDEAD_BEEF);
		send_cmd(CMD_INSERT, 6'd0, 32'h1);
		write_capacity(7'd0);
		send_cmd(CMD_APPEND, 6'd0, 32'h2);
		send_cmd(CMD_CLEAR, 6'd0, 32'h0);
		send_cmd(CMD_INSERT, 6'd0, 32'h3);
		write_capacity(7'd64);
		send_cmd(CMD_APPEND, 6'd0, 32'h4);
		send_cmd(CMD_APPEND, 6'd0, 32'h5);
		send_cmd(CMD_APPEND, 6'd0, 32'h6);
		write_capacity(7'd2);
		send_cmd(CMD_APPEND, 6'd0, 32'h7);
		send_cmd(CMD_REMOVE, 6'd1, 32'h0);
	endtask

	// Random commands, mostly well formed, grow_pct biases toward filling
	task automatic run_random_phase(logic [CNT_W-1:0] cap, int unsigned grow_pct,
			int unsigned n_items, bit idle_on);
		logic [CMD_W-1:0]  op;
		logic [POS_W-1:0]  pos;
		logic [DATA_W-1:0] val;
		int unsigned       pick;
		write_capacity(cap);
		allow_idle = idle_on;
		repeat (n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < grow_pct) begin
				op = ($urandom_range(0, 1) == 0) ? CMD_APPEND : CMD_INSERT;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 22) op = CMD_READ;
				else if (pick < 50) op = CMD_REMOVE;
				else if (pick < 70) op = CMD_OVERWRITE;
				else if (pick < 92) op = CMD_COMPARE;
				else if (pick < 95) op = CMD_CLEAR;
				else op = CMD_UNUSED;
			end
			// pick a position inside the list most of the time
			if ($urandom_range(0, 99) < 20) begin
				pos = POS_W'($urandom_range(0, 63));
			end else if (op == CMD_INSERT) begin
				pos = (list_len > 63) ? 6'd63 : POS_W'($urandom_range(0, list_len));
			end else begin
				pos = (list_len == 0) ? 6'd0 : POS_W'($urandom_range(0, list_len - 1));
			end
			pick = $urandom_range(0, 99);
			if (pick < 10) val = 32'h0;
			else if (pick < 20) val = 32'hFFFF_FFFF;
			else val = $urandom;
			// hit the equal case on half the in-range compares
			if (op == CMD_COMPARE && pos < list_len && $urandom_range(0, 1) == 1)
				val = list_mem[pos];
			send_cmd(op, pos, val);
		end
		allow_idle = 1'b1;
	endtask

	task automatic test_random_traffic();
		run_random_phase(7'd127, 85, 120, 1'b1);
		run_random_phase(7'd64, 50, 100, 1'b0);
		run_random_phase(7'd8, 50, 80, 1'b1);
		run_random_phase(7'd1, 50, 50, 1'b1);
		run_random_phase(7'd0, 50, 30, 1'b1);
		run_random_phase(7'd100, 70, 120, 1'b1);
		run_random_phase(7'd2, 50, 50, 1'b1);
		run_random_phase(CNT_W'($urandom_range(0, 127)), 55, 100, 1'b1);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		position = '0;
		value = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		list_len = 0;
		cap_reg = CAP_RESET;
		fail_count = 0;
		allow_idle = 1'b1;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		test_empty_list();
		test_basic_ops();
		test_capacity_edges();
		test_random_traffic();

		// drain, then leave room for any stray beat
		while (pending_results.size() != 0) @(posedge clk);
		repeat (LIST_DEPTH + 8) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#5ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule
